// ----- rtl/slw_pkg.sv -----
package slw_pkg;

  localparam int ADDR_W       = 15;
  localparam int LINK_W       = 7;
  localparam int LIMIT_W      = 10;
  localparam int CALC_W       = 12;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam int MAX_ENTRIES_DEFAULT   = 80;
  localparam int VISIBLE_LINES_DEFAULT = 224;

  localparam logic [1:0] REG_TABLE_BASE      = 2'd0;
  localparam logic [1:0] REG_WIDE_MODE       = 2'd1;
  localparam logic [1:0] REG_PRIORITY_SELECT = 2'd2;

  typedef struct packed {
    logic [31:0] attr_word_low;
    logic [31:0] attr_word_high;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic [ADDR_W-1:0] entry_address;
    logic [ADDR_W-1:0] next_address;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [LINK_W-1:0] table_base;
    logic              wide_mode;
    logic              priority_select;
  } cfg_t;

endpackage

// ----- rtl/slw_regs.sv -----
module slw_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slw_pkg::PADDR_W-1:0] paddr,
  input  logic [slw_pkg::PDATA_W-1:0] pwdata,
  output logic [slw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output slw_pkg::cfg_t               cfg_o
);
  import slw_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_TABLE_BASE:      cfg_d.table_base      = pwdata[LINK_W-1:0];
        REG_WIDE_MODE:       cfg_d.wide_mode       = pwdata[0];
        REG_PRIORITY_SELECT: cfg_d.priority_select = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_BASE:      prdata = {{(PDATA_W-LINK_W){1'b0}}, cfg_q.table_base};
      REG_WIDE_MODE:       prdata = {{(PDATA_W-1){1'b0}}, cfg_q.wide_mode};
      REG_PRIORITY_SELECT: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.priority_select};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/slw_core.sv -----
module slw_core #(
  parameter int MAX_ENTRIES   = slw_pkg::MAX_ENTRIES_DEFAULT,
  parameter int VISIBLE_LINES = slw_pkg::VISIBLE_LINES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slw_pkg::cfg_t      cfg_i,
  input  slw_pkg::in_item_t  item_i,
  input  logic               step_i,
  output slw_pkg::out_item_t result_o
);
  import slw_pkg::*;

  localparam logic [LINK_W-1:0]  MaxCount  = LINK_W'(MAX_ENTRIES);
  localparam logic [LIMIT_W-1:0] BotReset  = LIMIT_W'(VISIBLE_LINES);

  logic [LINK_W-1:0]  link_q, link_d, count_q, count_d, count_inc, link;
  logic [LIMIT_W-1:0] top_q, top_d, bot_q, bot_d, mf_q, mf_d, mt_q, mt_d;
  logic               held_q, held_d;
  logic [ADDR_W-1:0]  base, entry_addr, link_addr;
  logic               last;

  logic signed [CALC_W-1:0] top_s, bot_s, sy, to, mf, mt, sy_m, to_m, hgt, x, maxw;
  logic [2:0]               cells;
  logic                     visible, is_mask, acc;

  assign base = {cfg_i.table_base[LINK_W-1:1],
                 cfg_i.table_base[0] & ~cfg_i.wide_mode, 8'b0};
  assign link = item_i.attr_word_low[22:16];

  assign entry_addr = ADDR_W'(base + {6'b0, link_q, 2'b0}) & 15'h7ffc;
  assign link_addr  = ADDR_W'(base + {6'b0, link, 2'b0}) & 15'h7ffc;

  assign count_inc = count_q + 7'd1;
  assign last      = (link == '0) || (count_inc >= MaxCount);

  always_comb begin
    top_s   = $signed({{(CALC_W-LIMIT_W){top_q[LIMIT_W-1]}}, top_q});
    bot_s   = $signed({{(CALC_W-LIMIT_W){bot_q[LIMIT_W-1]}}, bot_q});
    mf      = $signed({{(CALC_W-LIMIT_W){mf_q[LIMIT_W-1]}}, mf_q});
    mt      = $signed({{(CALC_W-LIMIT_W){mt_q[LIMIT_W-1]}}, mt_q});
    cells   = {1'b0, item_i.attr_word_low[25:24]} + 3'd1;
    hgt     = $signed({6'b0, cells, 3'b0});
    sy      = $signed({3'b0, item_i.attr_word_low[8:0]}) - 12'sd128;
    to      = sy + hgt;
    visible = !(to <= top_s || sy > bot_s);
    is_mask = (item_i.attr_word_high[24:16] == 9'd0);
    x       = $signed({3'b0, item_i.attr_word_high[24:16]}) - 12'sd120;
    maxw    = cfg_i.wide_mode ? 12'sd328 : 12'sd264;
    acc     = 1'b0;
    sy_m    = sy;
    to_m    = to;

    top_d  = top_q;
    bot_d  = bot_q;
    mf_d   = mf_q;
    mt_d   = mt_q;
    held_d = held_q;

    if (visible) begin
      if (is_mask) begin
        if (held_q) begin
          if (mt + 12'sd1 >= sy && mt <= to && mf < sy) begin
            sy_m = mf;
          end else if (mf - 12'sd1 <= to && mf >= sy && mt > to) begin
            to_m = mt;
          end
        end
        if (sy_m <= top_s && to_m + 12'sd1 > top_s) begin
          top_d = LIMIT_W'(to_m + 12'sd1);
        end else if (to_m >= bot_s && sy_m - 12'sd1 < bot_s) begin
          bot_d = LIMIT_W'(sy_m - 12'sd1);
        end else begin
          mf_d   = LIMIT_W'(sy_m);
          mt_d   = LIMIT_W'(to_m);
          held_d = 1'b1;
        end
      end else if (item_i.attr_word_high[15] == cfg_i.priority_select) begin
        acc = !(x <= -12'sd24 || x >= maxw);
      end
    end

    if (last) begin
      link_d  = '0;
      count_d = '0;
      top_d   = '0;
      bot_d   = BotReset;
      mf_d    = '0;
      mt_d    = '0;
      held_d  = 1'b0;
    end else begin
      link_d  = link;
      count_d = count_inc;
    end
  end

  assign result_o.accepted      = acc;
  assign result_o.entry_address = entry_addr;
  assign result_o.next_address  = last ? (base & 15'h7ffc) : link_addr;
  assign result_o.last          = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= '0;
      count_q <= '0;
      top_q   <= '0;
      bot_q   <= BotReset;
      mf_q    <= '0;
      mt_q    <= '0;
      held_q  <= 1'b0;
    end else if (step_i) begin
      link_q  <= link_d;
      count_q <= count_d;
      top_q   <= top_d;
      bot_q   <= bot_d;
      mf_q    <= mf_d;
      mt_q    <= mt_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- rtl/sprite_list_walker_unit.sv -----
// Sprite attribute list walker: each request is one two-word sprite entry fetched at the
// next_address of the previous result (the table base after reset or after last). The block
// clips against the vertical limits, handles zero-x mask entries, flags visible sprites of the
// selected priority and returns one result per request, one entry per cycle unless the output
// stalls. Each entry passes the input register, then the result register, with the walk state
// (link, count, limits, mask range) updated as an entry leaves the input register. The user
// must write configuration through the APB port only while the walker is idle; not enforced.
module sprite_list_walker_unit #(
  parameter int MAX_ENTRIES   = slw_pkg::MAX_ENTRIES_DEFAULT,
  parameter int VISIBLE_LINES = slw_pkg::VISIBLE_LINES_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slw_pkg::PADDR_W-1:0] paddr,
  input  logic [slw_pkg::PDATA_W-1:0] pwdata,
  output logic [slw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  slw_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output slw_pkg::out_item_t          out_data_o
);
  import slw_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t out_q, result;
  logic      in_valid_q, in_valid_d, out_valid_q, out_valid_d, adv, in_take;

  slw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slw_core #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .step_i   (adv),
    .result_o (result)
  );

  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign in_take     = in_valid_i && in_ready_o;
  assign in_valid_d  = in_take || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
  end

endmodule

// ----- rtl/slw_checker.sv -----
module slw_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_ready_o,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  slw_pkg::out_item_t out_data_o
);

  // result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed under stall");

  // input side only stalls when the result register is full and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // end of walk restarts at the table base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.next_address[7:0] == 8'd0)
    else $error("restart address is not the table base");

  // entry addresses are four-word aligned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_address[1:0] == 2'd0
                 && out_data_o.next_address[1:0] == 2'd0)
    else $error("unaligned entry address");

endmodule

bind sprite_list_walker_unit slw_checker u_slw_checker (.*);

// ----- tb/sprite_list_walker_unit_test.sv -----
module sprite_list_walker_unit_test;
  import slw_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ENTRIES = 55;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  sprite_list_walker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  cfg_t walk_cfg = '0;
  logic [LINK_W-1:0] cur_link;
  logic [LINK_W-1:0] seen_count;
  logic [LIMIT_W-1:0] top_line;
  logic [LIMIT_W-1:0] bottom_line;
  logic [LIMIT_W-1:0] mask_first;
  logic [LIMIT_W-1:0] mask_last;
  logic mask_valid;
  out_item_t walk_results[$];

  bit gaps_on = 1'b1;
  int hold_len = 0;
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_entries = 0;
  int n_walks = 0;
  int n_shown = 0;
  int n_masks = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("sprite_list_walker_unit: mismatch");
      $finish;
    end
  end

  function automatic void restart_walk();
    cur_link = '0;
    seen_count = '0;
    top_line = '0;
    bottom_line = LIMIT_W'(VISIBLE_LINES_DEFAULT);
    mask_first = '0;
    mask_last = '0;
    mask_valid = 1'b0;
  endfunction

  function automatic out_item_t walk_entry(in_item_t e);
    out_item_t r;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] sum;
    logic [LINK_W-1:0] link;
    int top, bot, sy, hgt, sx, to, mf, mt, xpos, xmax;
    base = {walk_cfg.table_base[6:1], walk_cfg.table_base[0] & ~walk_cfg.wide_mode, 8'h00};
    sum = base + {6'd0, cur_link, 2'b00};
    r.accepted = 1'b0;
    r.entry_address = sum & 15'h7ffc;
    top = int'($signed(top_line));
    bot = int'($signed(bottom_line));
    sy = int'(e.attr_word_low[8:0]);
    sy = sy - 128;
    hgt = int'(e.attr_word_low[25:24]);
    hgt = (hgt + 1) * 8;
    sx = int'(e.attr_word_high[24:16]);
    xmax = walk_cfg.wide_mode ? 328 : 264;
    link = e.attr_word_low[22:16];
    if (!(sy + hgt <= top || sy > bot)) begin
      if (sx == 0) begin
        n_masks++;
        to = sy + hgt;
        if (mask_valid) begin
          mf = int'($signed(mask_first));
          mt = int'($signed(mask_last));
          if (mt + 1 >= sy && mt <= to && mf < sy) begin
            sy = mf;
          end else if (mf - 1 <= to && mf >= sy && mt > to) begin
            to = mt;
          end
        end
        if (sy <= top && to + 1 > top) begin
          top_line = LIMIT_W'(to + 1);
        end else if (to >= bot && sy - 1 < bot) begin
          bottom_line = LIMIT_W'(sy - 1);
        end else begin
          mask_first = LIMIT_W'(sy);
          mask_last = LIMIT_W'(to);
          mask_valid = 1'b1;
        end
      end else if (e.attr_word_high[15] == walk_cfg.priority_select) begin
        xpos = sx - 120;
        r.accepted = !(xpos <= -24 || xpos >= xmax);
      end
    end
    seen_count = seen_count + 7'd1;
    r.last = (link == '0) || (seen_count >= LINK_W'(MAX_ENTRIES_DEFAULT));
    if (r.last) begin
      r.next_address = base & 15'h7ffc;
      restart_walk();
    end else begin
      cur_link = link;
      sum = base + {6'd0, link, 2'b00};
      r.next_address = sum & 15'h7ffc;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) begin
      walk_results.push_back(walk_entry(in_data));
    end
  end

  task automatic report_mismatch(string what);
    if (errors < 40) begin
      $display("error: %s", what);
    end
    errors++;
  endtask

  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (walk_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = walk_results.pop_front();
        if (out_data.accepted !== want.accepted)
          report_mismatch($sformatf("entry %0d: accepted %b, expected %b",
                                    n_entries, out_data.accepted, want.accepted));
        if (out_data.entry_address !== want.entry_address)
          report_mismatch($sformatf("entry %0d: entry_address %h, expected %h",
                                    n_entries, out_data.entry_address, want.entry_address));
        if (out_data.next_address !== want.next_address)
          report_mismatch($sformatf("entry %0d: next_address %h, expected %h",
                                    n_entries, out_data.next_address, want.next_address));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("entry %0d: last %b, expected %b",
                                    n_entries, out_data.last, want.last));
        n_entries++;
        if (want.last) n_walks++;
        if (want.accepted) n_shown++;
      end
    end
  end

  // output side: random stalls, plus one long hold on request
  initial begin
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    bit ok;
    apb_access(1'b1, {idx, 2'b00}, value, readback);
    case (idx)
      REG_TABLE_BASE:      walk_cfg.table_base = value[LINK_W-1:0];
      REG_WIDE_MODE:       walk_cfg.wide_mode = value[0];
      REG_PRIORITY_SELECT: walk_cfg.priority_select = value[0];
      default: ;
    endcase
    if (idx != REG_NONE) begin
      apb_access(1'b0, {idx, 2'b00}, '0, readback);
      case (idx)
        REG_TABLE_BASE: ok = readback[LINK_W-1:0] == walk_cfg.table_base;
        REG_WIDE_MODE:  ok = readback[0] == walk_cfg.wide_mode;
        default:        ok = readback[0] == walk_cfg.priority_select;
      endcase
      if (!ok) report_mismatch($sformatf("register %0d reads %h", idx, readback));
    end
  endtask

  task automatic set_config(logic [LINK_W-1:0] base, logic wide, logic prio);
    write_register(REG_TABLE_BASE, {25'd0, base});
    write_register(REG_WIDE_MODE, {31'd0, wide});
    write_register(REG_PRIORITY_SELECT, {31'd0, prio});
  endtask

  task automatic send_request(in_item_t item);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (walk_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic in_item_t make_sprite(logic [8:0] y, logic [1:0] cells,
                                           logic [LINK_W-1:0] link, logic [8:0] x,
                                           logic prio);
    in_item_t e;
    e = '0;
    e.attr_word_low[8:0] = y;
    e.attr_word_low[25:24] = cells;
    e.attr_word_low[22:16] = link;
    e.attr_word_high[24:16] = x;
    e.attr_word_high[15] = prio;
    return e;
  endfunction

  function automatic in_item_t random_entry(logic [LINK_W-1:0] link);
    in_item_t e;
    e.attr_word_low = $urandom;
    e.attr_word_high = $urandom;
    if ($urandom_range(0, 7) != 0) e.attr_word_low[8:0] = 9'($urandom_range(9'h58, 9'h170));
    case ($urandom_range(0, 9))
      0, 1, 2: e.attr_word_high[24:16] = '0;
      3: ;
      default: e.attr_word_high[24:16] = 9'($urandom_range(9'h50, 9'h1d0));
    endcase
    e.attr_word_low[22:16] = link;
    return e;
  endfunction

  task automatic send_walk(int len, bit noisy);
    logic [LINK_W-1:0] link;
    bit broken;
    broken = noisy && ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if (broken) link = LINK_W'($urandom);
      else if (i == len - 1 && len < MAX_ENTRIES_DEFAULT) link = '0;
      else link = LINK_W'($urandom_range(1, 127));
      send_request(random_entry(link));
    end
  endtask

  task automatic send_random_walks(int count);
    int target;
    target = n_sent + count;
    while (n_sent < target) begin
      if ($urandom_range(0, 5) == 0) send_walk(MAX_ENTRIES_DEFAULT, 1'b1);
      else send_walk($urandom_range(1, 24), 1'b1);
    end
  endtask

  task automatic test_directed();
    send_request('0);
    send_request('1);
    send_request(make_sprite(9'h080, 2'd0, 7'd5, 9'h061, 1'b0));
    send_request(make_sprite(9'h080, 2'd0, 7'd6, 9'h060, 1'b0));
    send_request(make_sprite(9'h080, 2'd3, 7'd7, 9'h17f, 1'b0));
    send_request(make_sprite(9'h080, 2'd3, 7'd8, 9'h180, 1'b0));
    send_request(make_sprite(9'h080, 2'd0, 7'd9, 9'h100, 1'b1));
    // masks: raise top, hidden above, lower bottom, hidden below
    send_request(make_sprite(9'h080, 2'd0, 7'd10, 9'h000, 1'b0));
    send_request(make_sprite(9'h080, 2'd0, 7'd11, 9'h100, 1'b0));
    send_request(make_sprite(9'h15c, 2'd0, 7'd12, 9'h000, 1'b0));
    send_request(make_sprite(9'h15c, 2'd0, 7'd13, 9'h100, 1'b0));
    // held range, merged from below and above, then merged into top
    send_request(make_sprite(9'h0b2, 2'd0, 7'd14, 9'h000, 1'b0));
    send_request(make_sprite(9'h0ba, 2'd0, 7'd15, 9'h000, 1'b0));
    send_request(make_sprite(9'h0a8, 2'd1, 7'd16, 9'h000, 1'b0));
    send_request(make_sprite(9'h087, 2'd3, 7'd17, 9'h000, 1'b0));
    send_request(make_sprite(9'h100, 2'd2, 7'd0, 9'h100, 1'b0));
    wait_idle();
    set_config(7'h7f, 1'b1, 1'b1);
    send_request(make_sprite(9'h080, 2'd0, 7'd1, 9'h1bf, 1'b1));
    send_request(make_sprite(9'h080, 2'd0, 7'd2, 9'h1c0, 1'b1));
    send_request(make_sprite(9'h080, 2'd0, 7'd127, 9'h180, 1'b1));
    send_request(make_sprite(9'h080, 2'd0, 7'd0, 9'h100, 1'b0));
    wait_idle();
    write_register(REG_NONE, 32'hffff_ffff);
    write_register(REG_TABLE_BASE, 32'hffff_ffaa);
    write_register(REG_WIDE_MODE, 32'hffff_fffe);
    send_request(make_sprite(9'h0e4, 2'd1, 7'd3, 9'h100, 1'b1));
    send_request(make_sprite(9'h1ff, 2'd3, 7'd0, 9'h1ff, 1'b1));
    wait_idle();
  endtask

  task automatic test_longest_walk();
    set_config(7'h01, 1'b0, 1'b0);
    send_walk(MAX_ENTRIES_DEFAULT, 1'b0);
    send_walk(MAX_ENTRIES_DEFAULT, 1'b0);
    wait_idle();
  endtask

  task automatic test_full_stall();
    gaps_on = 1'b0;
    hold_len = 80;
    send_walk(30, 1'b0);
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_walks();
    set_config(7'h00, 1'b0, 1'b0);
    send_random_walks(PHASE_ENTRIES);
    wait_idle();
    set_config(7'h7f, 1'b1, 1'b1);
    send_random_walks(PHASE_ENTRIES);
    wait_idle();
    set_config(7'h7f, 1'b0, 1'b0);
    send_random_walks(PHASE_ENTRIES);
    wait_idle();
    set_config(7'h01, 1'b1, 1'b0);
    send_random_walks(PHASE_ENTRIES);
    for (int p = 0; p < 2; p++) begin
      wait_idle();
      set_config(LINK_W'($urandom), 1'($urandom), 1'($urandom));
      send_random_walks(PHASE_ENTRIES);
    end
    wait_idle();
  endtask

  task automatic test_streaming();
    gaps_on = 1'b0;
    set_config(LINK_W'($urandom), 1'($urandom), 1'($urandom));
    send_random_walks(PHASE_ENTRIES);
    wait_idle();
  endtask

  initial begin
    restart_walk();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_longest_walk();
    test_full_stall();
    test_random_walks();
    test_streaming();
    $display("walked %0d entries over %0d finished lists: %0d sprites accepted, %0d masks",
             n_entries, n_walks, n_shown, n_masks);
    $display("both screen widths, both priorities, table base extremes, long output hold");
    if (errors == 0) begin
      $display("sprite_list_walker_unit: match");
    end else begin
      $display("sprite_list_walker_unit: mismatch");
    end
    $finish;
  end

endmodule
